[src/dqs_pkg.sv]
// ----------------------------------------------------------------------------
// dqs_pkg: shared types and constants of the bounded deque with search
// Item layouts, command and status codes, cell operations and control states.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

	localparam int DQS_CAPACITY = 16;
	localparam int WORD_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd6;

	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		word_t            value;
	} in_item_t;

	typedef struct packed {
		word_t               front_value;
		word_t               back_value;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic                found;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN,
		CELL_APPEND,
		CELL_SEARCH,
		CELL_COMPACT,
		CELL_PROBE
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPACT,
		ST_BACK
	} dqs_state_t;

endpackage

`default_nettype wire

[src/dqs_cell.sv]
// ----------------------------------------------------------------------------
// dqs_cell: one storage cell of the deque chain
// Holds one entry, a search flag that ripples toward the back and a probe
// word that ripples toward the front.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_cell
	import dqs_pkg::*;
#(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_op_t         op,
	input  wire logic [CNT_W-1:0] cnt,
	input  wire word_t            value,
	input  wire word_t            prev_data,
	input  wire word_t            next_data,
	input  wire logic             prev_flag,
	input  wire word_t            next_probe,
	output word_t                 data,
	output logic                  flag,
	output logic                  hit,
	output word_t                 probe
);

	word_t data_q;
	word_t probe_q;
	logic  flag_q;
	logic  occupied;
	logic  is_end;
	logic  is_last;

	assign occupied = CNT_W'(IDX) < cnt;
	assign is_end   = CNT_W'(IDX) == cnt;
	assign is_last  = CNT_W'(IDX) == (cnt - CNT_W'(1));

	// first match at or in front of this cell
	assign hit = prev_flag | (occupied & (data_q == value));

	always_ff @(posedge clk) begin
		case (op)
			CELL_SHIFT_UP:   data_q <= prev_data;
			CELL_SHIFT_DOWN: data_q <= next_data;
			CELL_APPEND: begin
				if (is_end) begin
					data_q <= value;
				end
			end
			CELL_COMPACT: begin
				if (flag_q) begin
					data_q <= next_data;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == CELL_PROBE) begin
			probe_q <= is_last ? data_q : next_probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (op == CELL_SEARCH) begin
			flag_q <= hit;
		end
	end

	assign data  = data_q;
	assign flag  = flag_q;
	assign probe = probe_q;

endmodule

`default_nettype wire

[src/bounded_deque_with_search_unit.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit: fixed-capacity deque of signed words
// Chain of CAPACITY cells with push and pop at either end, plus search and remove.
// ----------------------------------------------------------------------------
// Push front, push back, pop front, peek, unused codes, pop back of the last
// entry, a search of an empty deque and every rejected command finish in the
// cycle they are accepted; such items are taken one per clock unless the
// result output stalls. Pop back that leaves entries then fetches the new back
// entry, which walks down the probe path one cell per clock. Contains and remove
// on a non-empty deque search as the flag ripples one cell per clock from the
// front to the back; a remove that hits then compacts and, if entries remain,
// fetches the new back entry. No item is taken while a search, compaction or
// fetch runs. A finished result waits in the output register while the next is accepted.
`default_nettype none

module bounded_deque_with_search_unit
	import dqs_pkg::*;
#(
	parameter int CAPACITY = DQS_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire in_item_t  cmd,
	output logic           res_valid,
	input  wire logic      res_stall,
	output out_item_t      res
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SCAN_W = $clog2(CAPACITY);

	dqs_state_t        state_q, state_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic [SCAN_W-1:0] scan_q;
	word_t             back_q;
	word_t             value_q;
	logic              is_remove_q;
	logic              found_q;
	logic [STATUS_W-1:0] status_q;
	logic              rpt_q;
	out_item_t         res_q;
	logic              res_valid_q;

	word_t cell_data  [CAPACITY];
	word_t cell_probe [CAPACITY];
	logic  cell_flag  [CAPACITY];
	logic  cell_hit   [CAPACITY];
	word_t cell_value;

	logic     accept;
	logic     load;
	logic     full;
	logic     empty;
	logic     scan_done;
	logic     last_hit;
	cell_op_t cell_op;
	logic     cnt_inc;
	logic     cnt_dec;
	logic     back_from_value;
	logic     back_from_probe;
	logic     found_ld;
	logic     found_val;
	logic     status_ld;
	logic [STATUS_W-1:0] status_val;
	logic     set_rpt;

	assign full      = cnt_q == CNT_W'(CAPACITY);
	assign empty     = cnt_q == '0;
	assign scan_done = scan_q == SCAN_W'(CAPACITY - 1);
	assign last_hit  = cell_hit[CAPACITY-1];

	assign load      = rpt_q & (~res_valid_q | ~res_stall);
	assign cmd_stall = ~((state_q == ST_IDLE) & (~rpt_q | load));
	assign accept    = cmd_valid & ~cmd_stall;

	assign cell_value = (state_q == ST_IDLE) ? cmd.value : value_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t prev_data;
		word_t next_data;
		logic  prev_flag;
		word_t next_probe;

		if (i == 0) begin : g_front
			assign prev_data = cell_value;
			assign prev_flag = 1'b0;
		end else begin : g_inner_front
			assign prev_data = cell_data[i-1];
			assign prev_flag = cell_flag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign next_data  = '0;
			assign next_probe = '0;
		end else begin : g_inner_back
			assign next_data  = cell_data[i+1];
			assign next_probe = cell_probe[i+1];
		end

		dqs_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (cell_op),
			.cnt        (cnt_q),
			.value      (cell_value),
			.prev_data  (prev_data),
			.next_data  (next_data),
			.prev_flag  (prev_flag),
			.next_probe (next_probe),
			.data       (cell_data[i]),
			.flag       (cell_flag[i]),
			.hit        (cell_hit[i]),
			.probe      (cell_probe[i])
		);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.command)
						CMD_POP_BACK: begin
							if (!empty && cnt_q != CNT_W'(1)) begin
								state_nxt = ST_BACK;
							end
						end
						CMD_CONTAINS, CMD_REMOVE: begin
							if (!empty) begin
								state_nxt = ST_SEARCH;
							end
						end
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (scan_done) begin
					state_nxt = (is_remove_q && last_hit) ? ST_COMPACT : ST_IDLE;
				end
			end
			ST_COMPACT: state_nxt = (cnt_q != CNT_W'(1)) ? ST_BACK : ST_IDLE;
			ST_BACK: begin
				if (scan_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cell_op         = CELL_HOLD;
		cnt_inc         = 1'b0;
		cnt_dec         = 1'b0;
		back_from_value = 1'b0;
		back_from_probe = 1'b0;
		found_ld        = 1'b0;
		found_val       = 1'b0;
		status_ld       = 1'b0;
		status_val      = STS_OK;
		set_rpt         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					found_ld  = 1'b1;
					status_ld = 1'b1;
					case (cmd.command)
						CMD_PUSH_FRONT: begin
							set_rpt = 1'b1;
							if (full) begin
								status_val = STS_OVERFLOW;
							end else begin
								cell_op         = CELL_SHIFT_UP;
								cnt_inc         = 1'b1;
								back_from_value = empty;
							end
						end
						CMD_PUSH_BACK: begin
							set_rpt = 1'b1;
							if (full) begin
								status_val = STS_OVERFLOW;
							end else begin
								cell_op         = CELL_APPEND;
								cnt_inc         = 1'b1;
								back_from_value = 1'b1;
							end
						end
						CMD_POP_FRONT: begin
							set_rpt = 1'b1;
							if (empty) begin
								status_val = STS_UNDERFLOW;
							end else begin
								cell_op = CELL_SHIFT_DOWN;
								cnt_dec = 1'b1;
							end
						end
						CMD_POP_BACK: begin
							if (empty) begin
								status_val = STS_UNDERFLOW;
								set_rpt    = 1'b1;
							end else begin
								cnt_dec = 1'b1;
								set_rpt = cnt_q == CNT_W'(1);
							end
						end
						CMD_CONTAINS, CMD_REMOVE: set_rpt = empty;
						default: set_rpt = 1'b1;
					endcase
				end
			end
			ST_SEARCH: begin
				cell_op = CELL_SEARCH;
				if (scan_done) begin
					found_ld  = 1'b1;
					found_val = last_hit;
					set_rpt   = ~(is_remove_q & last_hit);
				end
			end
			ST_COMPACT: begin
				cell_op = CELL_COMPACT;
				cnt_dec = 1'b1;
				set_rpt = cnt_q == CNT_W'(1);
			end
			ST_BACK: begin
				cell_op = CELL_PROBE;
				if (scan_done) begin
					back_from_probe = 1'b1;
					set_rpt         = 1'b1;
				end
			end
			default: cell_op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			rpt_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			// advance the scan only while searching or fetching the back entry
			if ((state_q == ST_SEARCH || state_q == ST_BACK) && !scan_done) begin
				scan_q <= scan_q + SCAN_W'(1);
			end else begin
				scan_q <= '0;
			end
			rpt_q <= set_rpt | (rpt_q & ~load);
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q     <= cmd.value;
			is_remove_q <= cmd.command == CMD_REMOVE;
		end
		if (back_from_value) begin
			back_q <= cmd.value;
		end else if (back_from_probe) begin
			back_q <= cell_probe[0];
		end
		if (found_ld) begin
			found_q <= found_val;
		end
		if (status_ld) begin
			status_q <= status_val;
		end
		if (load) begin
			res_q.front_value <= empty ? word_t'(0) : cell_data[0];
			res_q.back_value  <= empty ? word_t'(0) : back_q;
			res_q.count       <= COUNT_W'(cnt_q);
			res_q.is_empty    <= empty;
			res_q.found       <= found_q;
			res_q.status      <= status_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[src/dqs_checker.sv]
// ----------------------------------------------------------------------------
// dqs_checker: port-level checks for the bounded deque with search
// Watches the result channel for stability and self-consistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_checker
	import dqs_pkg::*;
#(
	parameter int CAPACITY = DQS_CAPACITY
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire out_item_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
	else $error("stalled result item changed or dropped");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_empty |->
			res.count == '0 && res.front_value == '0 && res.back_value == '0)
	else $error("empty result carries entries");

	a_fail_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != STS_OK |-> !res.found)
	else $error("rejected command reports a match");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STS_OVERFLOW |-> res.count == COUNT_W'(CAPACITY))
	else $error("overflow reported below capacity");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STS_UNDERFLOW |-> res.is_empty)
	else $error("underflow reported on a non-empty deque");

endmodule

bind bounded_deque_with_search_unit dqs_checker #(
	.CAPACITY (CAPACITY)
) u_dqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire

[tb/sv/bounded_deque_with_search_unit_test.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit_test: self-checking bench for the search deque
// Drives command items through a queue-fed driver. A shadow deque predicts
// each result view and the monitor compares it field by field. Phases vary
// the sender gaps and the receiver stalls, and one long output hold-off backs
// the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search_unit_test;
	import dqs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 475;
	localparam int MAX_REPORTS    = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_item_t  cmd = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res;

	bounded_deque_with_search_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// shadow copy of the deque, position 0 is the front
	word_t     shadow_entries [DQS_CAPACITY];
	int        shadow_count = 0;

	in_item_t  cmd_pending [$];
	out_item_t predicted_views [$];

	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      cmd_taken = 1'b0;
	logic      holdoff_armed = 1'b0;
	logic      holdoff_done = 1'b0;
	int        holdoff_left = 0;

	int        n_queued = 0;
	int        n_sent = 0;
	int        n_checked = 0;
	int        n_mismatch = 0;
	int        n_overflow = 0;
	int        n_underflow = 0;
	int        n_hits = 0;
	int        n_full = 0;
	int        cycle_count = 0;

	function automatic out_item_t shadow_deque_apply(input in_item_t it);
		out_item_t view;
		int        hit;
		view = '0;
		hit = -1;
		case (it.command)
			CMD_PUSH_FRONT: begin
				if (shadow_count >= DQS_CAPACITY) begin
					view.status = STS_OVERFLOW;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[0] = it.value;
					shadow_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (shadow_count >= DQS_CAPACITY) begin
					view.status = STS_OVERFLOW;
				end else begin
					shadow_entries[shadow_count] = it.value;
					shadow_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_count == 0) begin
					view.status = STS_UNDERFLOW;
				end else begin
					for (int i = 0; i < shadow_count - 1; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
			end
			CMD_POP_BACK: begin
				if (shadow_count == 0)
					view.status = STS_UNDERFLOW;
				else
					shadow_count--;
			end
			CMD_CONTAINS, CMD_REMOVE: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (hit < 0 && shadow_entries[i] == it.value)
						hit = i;
				end
				view.found = (hit >= 0);
				// close up the entries behind the first match
				if (it.command == CMD_REMOVE && hit >= 0) begin
					for (int i = hit; i < shadow_count - 1; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		if (shadow_count != 0) begin
			view.front_value = shadow_entries[0];
			view.back_value  = shadow_entries[shadow_count-1];
		end
		view.count    = COUNT_W'(shadow_count);
		view.is_empty = (shadow_count == 0);
		return view;
	endfunction

	task automatic check_view(input out_item_t got);
		out_item_t want;
		if (predicted_views.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= MAX_REPORTS)
				$display("ERROR: result with nothing expected: %p", got);
		end else begin
			want = predicted_views.pop_front();
			n_checked++;
			if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
					got.count !== want.count || got.is_empty !== want.is_empty ||
					got.found !== want.found || got.status !== want.status) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("ERROR: result %0d expected %p got %p", n_checked, want, got);
			end
			if (want.status == STS_OVERFLOW)
				n_overflow++;
			if (want.status == STS_UNDERFLOW)
				n_underflow++;
			if (want.found)
				n_hits++;
			if (want.count == COUNT_W'(DQS_CAPACITY))
				n_full++;
		end
	endtask

	task automatic enqueue_cmd(input logic [CMD_W-1:0] c, input word_t v);
		in_item_t it;
		it.command = c;
		it.value   = v;
		cmd_pending.push_back(it);
		n_queued++;
	endtask

	task automatic enqueue_random(input int n);
		word_t             value_pool [8];
		int                push_bias;
		int                r;
		logic [CMD_W-1:0]  c;
		word_t             v;
		value_pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
			32'sd5, 32'sd123456, -32'sd42};
		push_bias = 50;
		for (int k = 0; k < n; k++) begin
			// redraw the push/pop balance so the fill level sweeps empty to full
			if (k % 50 == 0)
				push_bias = $urandom_range(85, 15);
			r = $urandom_range(99);
			if (r < 12)
				c = CMD_CONTAINS;
			else if (r < 24)
				c = CMD_REMOVE;
			else if (r < 28)
				c = CMD_PEEK;
			else if (r < 30)
				c = CMD_UNUSED;
			else if ($urandom_range(99) < push_bias)
				c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
			// mostly pool values so searches hit
			if ($urandom_range(99) < 70)
				v = value_pool[$urandom_range(7)];
			else
				v = $urandom;
			enqueue_cmd(c, v);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_sent != n_queued || predicted_views.size() != 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver: advance to the next item after an accept, hold while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_taken) begin
			if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd       <= cmd_pending.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a one-time long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (holdoff_armed && !holdoff_done) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_CYCLES - 1;
			res_stall <= 1'b1;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: predict on each accepted command, check each accepted result
	always @(posedge clk) begin
		cmd_taken <= arst_n && cmd_valid && !cmd_stall;
		if (arst_n && cmd_valid && !cmd_stall) begin
			predicted_views.push_back(shadow_deque_apply(cmd));
			n_sent++;
		end
		if (arst_n && res_valid && !res_stall)
			check_view(res);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// empty deque corner cases
		enqueue_cmd(CMD_POP_FRONT, 32'sd0);
		enqueue_cmd(CMD_POP_BACK, 32'sd0);
		enqueue_cmd(CMD_REMOVE, 32'sd0);
		enqueue_cmd(CMD_CONTAINS, 32'sd0);
		enqueue_cmd(CMD_UNUSED, 32'sd0);
		enqueue_cmd(CMD_PUSH_FRONT, 32'sh80000000);
		enqueue_cmd(CMD_PUSH_BACK, 32'sh7fffffff);
		// fill to capacity, last entry at the back is -1
		for (int i = 0; i < 13; i++)
			enqueue_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, word_t'(i * 3 + 7));
		enqueue_cmd(CMD_PUSH_BACK, -32'sd1);
		enqueue_cmd(CMD_PUSH_BACK, 32'sd99);
		enqueue_cmd(CMD_PUSH_FRONT, 32'sd99);
		enqueue_cmd(CMD_CONTAINS, 32'sh7fffffff);
		enqueue_cmd(CMD_REMOVE, -32'sd1);
		enqueue_cmd(CMD_REMOVE, 32'sd777);
		enqueue_cmd(CMD_PEEK, 32'sd0);
		enqueue_cmd(CMD_POP_BACK, 32'sd0);
		enqueue_cmd(CMD_POP_FRONT, 32'sd0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// no idling, with the receiver held off to back the block up
		@(posedge clk);
		holdoff_armed = 1'b1;
		enqueue_random(PHASE_ITEMS);
		wait_drained();

		@(posedge clk);
		send_idle_pct = 77;
		recv_stall_pct = 0;
		enqueue_random(PHASE_ITEMS);
		wait_drained();

		@(posedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		enqueue_random(PHASE_ITEMS);
		wait_drained();

		@(posedge clk);
		send_idle_pct = 28;
		recv_stall_pct = 28;
		enqueue_random(PHASE_ITEMS);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d commands and checked %0d results over four stall patterns.",
			n_sent, n_checked);
		$display("Saw %0d overflows, %0d underflows, %0d search hits, %0d full views.",
			n_overflow, n_underflow, n_hits, n_full);
		if (n_mismatch == 0 && predicted_views.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("ERROR: %0d mismatches, %0d results missing", n_mismatch,
				predicted_views.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
